// ===== rtl/core/gauss_jordan_matrix_inverse_assert.svh =====
// Assertion macros for the Gauss-Jordan inverse block.
// Used by the top level only; no other dependencies.
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_ASSERT_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define GJINV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define GJINV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gjinv_pkg.sv =====
// Shared types and constants of the Gauss-Jordan inverse block.
// No dependencies; used by gjinv_ctrl, gjinv_dp and the top level.
`timescale 1ns / 1ps
package gjinv_pkg;

    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int DIV_STEPS = 48;

    localparam logic [DIM_W-1:0]  DIM_RESET = 4'd3;
    localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;

    // write source select
    localparam logic [1:0] WS_LOAD = 2'd0;
    localparam logic [1:0] WS_SUB  = 2'd1;
    localparam logic [1:0] WS_DIV  = 2'd2;

    typedef struct packed {
        logic       wr_work;
        logic       wr_comp;
        logic [1:0] wr_src;
        logic       ident;
        logic       sel_a;
        logic       sel_b;
        logic       div_start;
        logic       m_load;
        logic       mul_go;
        logic       scl_go;
        logic       set_sing;
        logic       out_load;
        logic       out_last;
        logic       clr_flags;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic piv_zero;
        logic out_fire;
    } t_dp_st;

endpackage

// ===== rtl/core/gjinv_dp.sv =====
// Datapath of the Gauss-Jordan inverse: matrix memories, shared divider,
// multiply/scale/subtract unit, sticky flags and output register. Uses gjinv_pkg.
`timescale 1ns / 1ps
module gjinv_dp
    import gjinv_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [AW-1:0]            i_ra,
    input  logic [AW-1:0]            i_rb,
    input  logic [AW-1:0]            i_wa,
    input  logic signed [DATA_W-1:0] i_elem,
    input  logic                     i_out_ready,
    output t_dp_st                   o_st,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_last,
    output logic                     o_valid,
    output logic                     o_singular,
    output logic                     o_overflow
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_W-1:0] r_work [DEPTH];
    logic [DATA_W-1:0] r_comp [DEPTH];
    logic [DATA_W-1:0] r_work_a, r_work_b, r_comp_a, r_comp_b;

    logic signed [DATA_W-1:0] op_a, op_b;

    // divider
    logic              r_dbusy, r_ddone, r_dneg;
    logic [5:0]        r_dcnt;
    logic [31:0]       r_dvs;
    logic [47:0]       r_dq;
    logic [32:0]       r_rem;
    logic [32:0]       rem_sh, rem_n;
    logic              rem_ge;
    logic              div_sat;
    logic [DATA_W-1:0] div_res;

    // multiply / scale / subtract
    logic signed [DATA_W-1:0] r_m, r_hb, r_scl;
    logic signed [63:0]       r_prod;
    logic signed [63:0]       p_adj, p_sh;
    logic                     scl_sat;
    logic [DATA_W-1:0]        scl_res;
    logic signed [32:0]       diff;
    logic                     sub_sat;
    logic [DATA_W-1:0]        sub_res;

    logic r_sing, r_ovf;
    logic r_out_valid, r_out_last;
    logic [DATA_W-1:0] r_out_value;

    logic [DATA_W-1:0] wd_work, wd_comp;

    assign op_a = i_cmd.sel_a ? r_comp_a : r_work_a;
    assign op_b = i_cmd.sel_b ? r_comp_b : r_work_b;

    // memories: one write, two registered reads each
    always_comb begin
        wd_work = (i_cmd.wr_src == WS_LOAD) ? i_elem : sub_res;
        unique case (i_cmd.wr_src)
            WS_LOAD: wd_comp = i_cmd.ident ? Q_ONE : '0;
            WS_SUB:  wd_comp = sub_res;
            default: wd_comp = div_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_work) begin
            r_work[i_wa] <= wd_work;
        end
        if (i_cmd.wr_comp) begin
            r_comp[i_wa] <= wd_comp;
        end
        r_work_a <= r_work[i_ra];
        r_work_b <= r_work[i_rb];
        r_comp_a <= r_comp[i_ra];
        r_comp_b <= r_comp[i_rb];
    end

    // restoring divider, one quotient bit a cycle: quotient = (b << 16) / a
    assign rem_sh = {r_rem[31:0], r_dq[47]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});
    assign rem_n  = rem_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    assign div_sat = (|r_dq[47:32]) || (r_dq[31] && (!r_dneg || (|r_dq[30:0])));
    always_comb begin
        if (div_sat) begin
            div_res = r_dneg ? Q_MIN : Q_MAX;
        end else begin
            div_res = r_dneg ? (~r_dq[31:0] + 32'd1) : r_dq[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == 6'd1) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_dneg <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            r_dvs  <= op_a[DATA_W-1] ? (~op_a + 32'd1) : op_a;
            r_dq   <= {(op_b[DATA_W-1] ? (~op_b + 32'd1) : op_b), 16'h0000};
            r_rem  <= '0;
            r_dcnt <= 6'(DIV_STEPS);
        end else if (r_dbusy) begin
            r_rem  <= rem_n;
            r_dq   <= {r_dq[46:0], rem_ge};
            r_dcnt <= r_dcnt - 6'd1;
        end
    end

    // product truncated toward zero, then saturate
    assign p_adj   = r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0);
    assign p_sh    = p_adj >>> 16;
    assign scl_sat = !((&p_sh[63:31]) || !(|p_sh[63:31]));
    assign scl_res = scl_sat ? (p_sh[63] ? Q_MIN : Q_MAX) : p_sh[31:0];

    assign diff    = {r_hb[DATA_W-1], r_hb} - {r_scl[DATA_W-1], r_scl};
    assign sub_sat = diff[32] ^ diff[31];
    assign sub_res = sub_sat ? (diff[32] ? Q_MIN : Q_MAX) : diff[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_load) begin
            r_m <= div_res;
        end
        if (i_cmd.mul_go) begin
            r_prod <= r_m * op_a;
            r_hb   <= op_b;
        end
        if (i_cmd.scl_go) begin
            r_scl <= scl_res;
        end
    end

    // sticky flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sing      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_flags) begin
                r_sing <= 1'b0;
                r_ovf  <= 1'b0;
            end else begin
                if (i_cmd.set_sing) begin
                    r_sing <= 1'b1;
                end
                if ((i_cmd.scl_go && scl_sat) || (r_ddone && div_sat)
                    || (i_cmd.wr_src == WS_SUB && (i_cmd.wr_work || i_cmd.wr_comp)
                        && sub_sat)) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_sing ? '0 : op_b;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_st.div_done = r_ddone;
    assign o_st.piv_zero = (op_a == '0);
    assign o_st.out_fire = r_out_valid && i_out_ready;

    assign o_value    = r_out_value;
    assign o_last     = r_out_last;
    assign o_valid    = r_out_valid;
    assign o_singular = r_sing;
    assign o_overflow = r_ovf;

endmodule

// ===== rtl/core/gjinv_ctrl.sv =====
// Sequencer of the Gauss-Jordan inverse: load counters, elimination order,
// diagonal check, result divisions and emission. Uses gjinv_pkg.
`timescale 1ns / 1ps
module gjinv_ctrl
    import gjinv_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_dim,
    input  logic             i_in_fire,
    output logic             o_in_ready,
    input  t_dp_st           i_st,
    output t_dp_cmd          o_cmd,
    output logic [AW-1:0]    o_ra,
    output logic [AW-1:0]    o_rb,
    output logic [AW-1:0]    o_wa
);

    localparam int IW = $clog2(MAX_DIM);
    localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PIV   = 4'd1;
    localparam logic [3:0] S_PCHK  = 4'd2;
    localparam logic [3:0] S_PDIV  = 4'd3;
    localparam logic [3:0] S_ERD   = 4'd4;
    localparam logic [3:0] S_EMUL  = 4'd5;
    localparam logic [3:0] S_ESCL  = 4'd6;
    localparam logic [3:0] S_ESUB  = 4'd7;
    localparam logic [3:0] S_DRD   = 4'd8;
    localparam logic [3:0] S_DCHK  = 4'd9;
    localparam logic [3:0] S_RRD   = 4'd10;
    localparam logic [3:0] S_RST   = 4'd11;
    localparam logic [3:0] S_RDIV  = 4'd12;
    localparam logic [3:0] S_XRD   = 4'd13;
    localparam logic [3:0] S_XLD   = 4'd14;
    localparam logic [3:0] S_XWAIT = 4'd15;

    logic [3:0]       r_state, n_state;
    logic [DIM_W-1:0] r_dim, n_dim;
    logic [IW-1:0]    r_k, n_k, r_row, n_row, r_col, n_col;
    logic             r_sel, n_sel, r_bwd, n_bwd;
    logic [IW-1:0]    nm1;
    logic             col_end, row_end;

    function automatic logic [AW-1:0] addr(input logic [IW-1:0] row,
                                           input logic [IW-1:0] col);
        return AW'(row) * STRIDE + AW'(col);
    endfunction

    always_comb begin
        if (r_dim == '0) begin
            nm1 = '0;
        end else if (int'(r_dim) > MAX_DIM) begin
            nm1 = IW'(MAX_DIM - 1);
        end else begin
            nm1 = IW'(r_dim - 4'd1);
        end
    end

    assign col_end = (r_col == nm1);
    assign row_end = (r_row == nm1);

    always_comb begin
        n_state = r_state;
        n_dim   = r_dim;
        n_k     = r_k;
        n_row   = r_row;
        n_col   = r_col;
        n_sel   = r_sel;
        n_bwd   = r_bwd;
        o_cmd   = '0;
        o_ra    = addr(r_k, r_col);
        o_rb    = addr(r_row, r_col);
        o_wa    = addr(r_row, r_col);
        o_in_ready = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.wr_work = 1'b1;
                    o_cmd.wr_comp = 1'b1;
                    o_cmd.wr_src  = WS_LOAD;
                    o_cmd.ident   = (r_row == r_col);
                    if (!col_end) begin
                        n_col = r_col + 1'b1;
                    end else if (!row_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = '0;
                        n_bwd = 1'b0;
                        n_k   = '0;
                        if (nm1 == '0) begin
                            n_row   = '0;
                            n_state = S_DRD;
                        end else begin
                            n_row   = IW'(1);
                            n_state = S_PIV;
                        end
                    end
                end
            end
            S_PIV: begin
                o_ra = addr(r_k, r_k);
                o_rb = addr(r_row, r_k);
                n_state = S_PCHK;
            end
            S_PCHK: begin
                o_ra = addr(r_k, r_k);
                o_rb = addr(r_row, r_k);
                if (i_st.piv_zero) begin
                    o_cmd.set_sing = 1'b1;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_XRD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_PDIV;
                end
            end
            S_PDIV: begin
                if (i_st.div_done) begin
                    o_cmd.m_load = 1'b1;
                    n_col   = '0;
                    n_sel   = 1'b0;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                o_cmd.sel_a = r_sel;
                o_cmd.sel_b = r_sel;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.sel_a  = r_sel;
                o_cmd.sel_b  = r_sel;
                o_cmd.mul_go = 1'b1;
                n_state = S_ESCL;
            end
            S_ESCL: begin
                o_cmd.scl_go = 1'b1;
                n_state = S_ESUB;
            end
            S_ESUB: begin
                o_cmd.wr_src  = WS_SUB;
                o_cmd.wr_work = !r_sel;
                o_cmd.wr_comp = r_sel;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_ERD;
                end else if (!col_end) begin
                    n_sel   = 1'b0;
                    n_col   = r_col + 1'b1;
                    n_state = S_ERD;
                end else begin
                    n_sel   = 1'b0;
                    n_state = S_PIV;
                    // pick the next (row, pivot) pair
                    if (!r_bwd) begin
                        if (!row_end) begin
                            n_row = r_row + 1'b1;
                        end else if ({1'b0, r_k} + 1'b1 < {1'b0, nm1}) begin
                            n_k   = r_k + 1'b1;
                            n_row = r_k + IW'(2);
                        end else begin
                            n_bwd = 1'b1;
                            n_k   = nm1;
                            n_row = nm1 - 1'b1;
                        end
                    end else begin
                        if (r_row != '0) begin
                            n_row = r_row - 1'b1;
                        end else if (r_k > IW'(1)) begin
                            n_k   = r_k - 1'b1;
                            n_row = r_k - IW'(2);
                        end else begin
                            n_row   = '0;
                            n_state = S_DRD;
                        end
                    end
                end
            end
            S_DRD: begin
                o_ra = addr(r_row, r_row);
                n_state = S_DCHK;
            end
            S_DCHK: begin
                o_ra = addr(r_row, r_row);
                if (i_st.piv_zero) begin
                    o_cmd.set_sing = 1'b1;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_XRD;
                end else if (row_end) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_RRD;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_DRD;
                end
            end
            S_RRD: begin
                o_ra = addr(r_row, r_row);
                o_cmd.sel_b = 1'b1;
                n_state = S_RST;
            end
            S_RST: begin
                o_ra = addr(r_row, r_row);
                o_cmd.sel_b     = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_RDIV;
            end
            S_RDIV: begin
                if (i_st.div_done) begin
                    o_cmd.wr_comp = 1'b1;
                    o_cmd.wr_src  = WS_DIV;
                    n_state = S_RRD;
                    if (!col_end) begin
                        n_col = r_col + 1'b1;
                    end else if (!row_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col   = '0;
                        n_row   = '0;
                        n_state = S_XRD;
                    end
                end
            end
            S_XRD: begin
                o_cmd.sel_b = 1'b1;
                n_state = S_XLD;
            end
            S_XLD: begin
                o_cmd.sel_b    = 1'b1;
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = col_end && row_end;
                n_state = S_XWAIT;
            end
            S_XWAIT: begin
                if (i_st.out_fire) begin
                    n_state = S_XRD;
                    if (!col_end) begin
                        n_col = r_col + 1'b1;
                    end else if (!row_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        o_cmd.clr_flags = 1'b1;
                        n_col   = '0;
                        n_row   = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase

        // a new order restarts the load
        if (i_cfg_we) begin
            n_dim = i_cfg_dim;
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dim   <= DIM_RESET;
            r_k     <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_sel   <= 1'b0;
            r_bwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;
            r_k     <= n_k;
            r_row   <= n_row;
            r_col   <= n_col;
            r_sel   <= n_sel;
            r_bwd   <= n_bwd;
        end
    end

endmodule

// ===== rtl/core/gauss_jordan_matrix_inverse.sv =====
// Top level of the Gauss-Jordan matrix inverse block (Q16.16).
// Depends on gjinv_pkg, gjinv_ctrl, gjinv_dp and the assertion macro header.
`timescale 1ns / 1ps
// Usage:
//  - Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the
//    order n (0 acts as 1, above MAX_DIM acts as MAX_DIM); a write restarts
//    the load. Write it only while the block is idle.
//  - Input channel (i_valid / o_ready / i_elem_value) takes the n*n matrix
//    words in row-major order, one per cycle while loading.
//  - After the last word the block eliminates with one shared unit: each of
//    the n*(n-1) row updates runs a pivot check and a division, then a
//    multiply/subtract over its n columns in both the work and the companion
//    matrix; then come n diagonal checks and n*n result divisions. The
//    48-step serial divider and the single multiply/subtract unit set the
//    throughput of the block.
//  - Output channel (o_valid / i_ready) then gives the n*n inverse words in
//    row-major order, each only after the one before it is taken, with
//    o_last_elem on the final one. o_singular and o_overflow hold on every
//    word of a matrix; a singular matrix gives all-zero words.
//  - A stalled receiver holds the output register; the block waits and takes
//    no new input word until the whole inverse is delivered.
//  - Reset (synchronous, active low) sets n to 3, drops any partial load and
//    clears both flags and the output valid.
module gauss_jordan_matrix_inverse
    import gjinv_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_elem_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_inv_value,
    output logic                     o_last_elem,
    output logic                     o_singular,
    output logic                     o_overflow
);

`include "gauss_jordan_matrix_inverse_assert.svh"

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    t_dp_cmd       cmd;
    t_dp_st        st;
    logic [AW-1:0] ra, rb, wa;
    logic          in_ready;

    // the register write is always taken
    assign o_cfg_ready = 1'b1;
    assign o_ready     = in_ready;

    gjinv_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_dim  (i_cfg_data),
        .i_in_fire  (i_valid && in_ready),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_ra       (ra),
        .o_rb       (rb),
        .o_wa       (wa)
    );

    gjinv_dp #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_ra        (ra),
        .i_rb        (rb),
        .i_wa        (wa),
        .i_elem      (i_elem_value),
        .i_out_ready (i_ready),
        .o_st        (st),
        .o_value     (o_inv_value),
        .o_last      (o_last_elem),
        .o_valid     (o_valid),
        .o_singular  (o_singular),
        .o_overflow  (o_overflow)
    );

    // loading and emitting never overlap
    `GJINV_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready, "load during emission")
    // a singular matrix gives zero words
    `GJINV_ASSERT_NOW(a_sing_zero, i_clk, i_rst_n, o_valid && o_singular, o_inv_value == '0, "nonzero singular word")
    // after the final word the block is ready for the next matrix
    `GJINV_ASSERT_NEXT(a_last_ready, i_clk, i_rst_n, o_valid && i_ready && o_last_elem, o_ready && !o_valid && !o_singular && !o_overflow, "not back to load")

endmodule
